// ===== rtl/vfo_pkg.sv =====
// Shared types and constants for the VFO tuner with tone select.
`default_nettype none

package vfo_pkg;

    localparam int FREQ_W       = 32;
    localparam int STEP_W       = 20;
    localparam int OFFSET_W     = 25;
    localparam int COUNT_W      = 6;
    localparam int TONE_W       = 6;
    localparam int DIV_W        = STEP_W;
    localparam int CFG_ADDR_W   = 3;
    localparam int CFG_DATA_W   = 32;
    localparam int S_TDATA_W    = 40;
    localparam int M_TDATA_W    = 72;
    localparam int WIDE_W       = 35;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_FREQ_MIN      = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_FREQ_MAX      = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_STEP_SIZE     = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_DUPLEX_OFFSET = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_TONE_MODE     = 3'd4;

    // Reset values
    localparam logic [FREQ_W-1:0]   FREQ_MIN_RST      = 32'd144000000;
    localparam logic [FREQ_W-1:0]   FREQ_MAX_RST      = 32'd146000000;
    localparam logic [STEP_W-1:0]   STEP_SIZE_RST     = 20'd12500;
    localparam logic [OFFSET_W-1:0] DUPLEX_OFFSET_RST = 25'(-600000);

    // Command codes
    localparam logic CMD_TUNE = 1'b0;
    localparam logic CMD_SET  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_DIV,
        ST_WRAP,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic              start;
        logic [FREQ_W-1:0] dividend;
        logic [DIV_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] rem;
    } div_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/vfo_tuner_with_tone_select.sv =====
// Top level of the VFO tuner: config registers, sequencer and frequency datapath.
`default_nettype none

// A set command clamps its new frequency into the band in the start step and
// then loads the result in the output step. A tune command runs either the
// snap of the frequency to the step grid or the wrap of the tone index through
// one restoring remainder unit. That unit retires one dividend bit per cycle
// and flags completion through a registered done flag. Around it come a setup
// step, a wrap step for frequency tuning, and the output load. The next
// transaction can be taken in the cycle after the result is loaded. The block
// takes one item at a time, and s_tready is high only while the sequencer is
// idle. A result can wait in the output register while the next item is
// accepted. The sequencer holds in its output step only while an earlier
// result is still waiting there.
module vfo_tuner_with_tone_select #(
    parameter int TONE_COUNT = 50
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              cfg_wr_en,
    input  wire  [vfo_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  wire  [vfo_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  wire                              s_tvalid,
    output logic                             s_tready,
    // step_count[5:0], new_frequency[37:6], reverse[38], zero fill
    input  wire  [vfo_pkg::S_TDATA_W-1:0]    s_tdata,
    // command[0]
    input  wire  [0:0]                       s_tuser,
    output logic                             m_tvalid,
    input  wire                              m_tready,
    // rx_frequency[31:0], tx_frequency[63:32], tone_index[69:64],
    // tone_on[70], zero fill
    output logic [vfo_pkg::M_TDATA_W-1:0]    m_tdata
);
    import vfo_pkg::*;

    // Smallest multiple of the table size that lifts any index sum to zero or above
    localparam int TONE_BIAS = TONE_COUNT * ((32 + TONE_COUNT - 1) / TONE_COUNT);

    // Configuration registers
    logic [FREQ_W-1:0]   freq_min_reg;
    logic [FREQ_W-1:0]   freq_max_reg;
    logic [STEP_W-1:0]   step_size_reg;
    logic [OFFSET_W-1:0] duplex_offset_reg;
    logic                tone_mode_reg;

    // Item and state registers
    logic                       command_reg;
    logic signed [COUNT_W-1:0]  step_count_reg;
    logic [FREQ_W-1:0]          new_freq_reg;
    logic                       reverse_reg;
    logic [FREQ_W-1:0]          stored_freq_reg;
    logic [TONE_W-1:0]          tone_pos_reg;
    logic signed [26:0]         prod_reg;
    logic signed [WIDE_W-1:0]   f_reg;
    logic [M_TDATA_W-1:0]       out_data_reg;
    logic                       out_valid_reg;

    state_t state_reg, state_next;

    // Sequencer outputs
    logic start_div, load_clamp, load_tone, load_snap, load_wrap, load_out;

    div_req_t div_req;
    div_rsp_t div_rsp;

    logic [STEP_W-1:0]        step_eff;
    logic signed [8:0]        tone_sum;
    logic [FREQ_W-1:0]        clamp_freq;
    logic signed [WIDE_W-1:0] lo_w, hi_w, step_w, wrap_f;
    logic [FREQ_W-1:0]        off32;
    logic                     in_accept;
    logic                     out_free;

    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;
    assign step_eff  = (step_size_reg == '0) ? STEP_W'(1) : step_size_reg;
    assign tone_sum  = signed'({3'b000, tone_pos_reg}) + 9'(step_count_reg)
                     + 9'(TONE_BIAS);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            freq_min_reg      <= FREQ_MIN_RST;
            freq_max_reg      <= FREQ_MAX_RST;
            step_size_reg     <= STEP_SIZE_RST;
            duplex_offset_reg <= DUPLEX_OFFSET_RST;
            tone_mode_reg     <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_FREQ_MIN:      freq_min_reg      <= cfg_wdata;
                CFG_FREQ_MAX:      freq_max_reg      <= cfg_wdata;
                CFG_STEP_SIZE:     step_size_reg     <= cfg_wdata[STEP_W-1:0];
                CFG_DUPLEX_OFFSET: duplex_offset_reg <= cfg_wdata[OFFSET_W-1:0];
                CFG_TONE_MODE:     tone_mode_reg     <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (in_accept) state_next = ST_START;
            ST_START: state_next = (command_reg == CMD_SET) ? ST_OUT : ST_DIV;
            ST_DIV: begin
                if (div_rsp.done) state_next = tone_mode_reg ? ST_OUT : ST_WRAP;
            end
            ST_WRAP:  state_next = ST_OUT;
            ST_OUT:   if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        s_tready   = 1'b0;
        start_div  = 1'b0;
        load_clamp = 1'b0;
        load_tone  = 1'b0;
        load_snap  = 1'b0;
        load_wrap  = 1'b0;
        load_out   = 1'b0;
        unique case (state_reg)
            ST_IDLE:  s_tready = 1'b1;
            ST_START: begin
                load_clamp = (command_reg == CMD_SET);
                start_div  = (command_reg == CMD_TUNE);
            end
            ST_DIV: begin
                load_tone = div_rsp.done && tone_mode_reg;
                load_snap = div_rsp.done && !tone_mode_reg;
            end
            ST_WRAP:  load_wrap = 1'b1;
            ST_OUT:   load_out = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign div_req.start    = start_div;
    assign div_req.dividend = tone_mode_reg ? FREQ_W'(unsigned'(tone_sum))
                                            : stored_freq_reg;
    assign div_req.divisor  = tone_mode_reg ? DIV_W'(TONE_COUNT) : step_eff;

    vfo_rem_unit u_rem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    always_comb begin
        if (new_freq_reg < freq_min_reg) begin
            clamp_freq = freq_min_reg;
        end else if (new_freq_reg > freq_max_reg) begin
            clamp_freq = freq_max_reg;
        end else begin
            clamp_freq = new_freq_reg;
        end
    end

    assign lo_w   = signed'({3'b000, freq_min_reg});
    assign hi_w   = signed'({3'b000, freq_max_reg});
    assign step_w = signed'({15'b0, step_eff});

    // Wrap once past either band edge, upper edge first
    always_comb begin
        if (f_reg > hi_w) begin
            wrap_f = lo_w + f_reg - hi_w - step_w;
        end else if (f_reg < lo_w) begin
            wrap_f = hi_w - (lo_w - f_reg) + step_w;
        end else begin
            wrap_f = f_reg;
        end
    end

    assign off32 = FREQ_W'(signed'(duplex_offset_reg));

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            command_reg    <= s_tuser[0];
            step_count_reg <= signed'(s_tdata[5:0]);
            new_freq_reg   <= s_tdata[37:6];
            reverse_reg    <= s_tdata[38];
        end
        if (start_div) begin
            prod_reg <= step_count_reg * signed'({1'b0, step_eff});
        end
        if (load_snap) begin
            f_reg <= signed'({3'b000, stored_freq_reg})
                   - signed'({15'b0, div_rsp.rem}) + WIDE_W'(prod_reg);
        end
        if (load_out) begin
            out_data_reg <= {1'b0, tone_mode_reg, tone_pos_reg,
                             reverse_reg ? stored_freq_reg : stored_freq_reg + off32,
                             reverse_reg ? stored_freq_reg + off32 : stored_freq_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stored_freq_reg <= FREQ_MIN_RST;
            tone_pos_reg    <= '0;
            out_valid_reg   <= 1'b0;
        end else begin
            if (load_clamp) begin
                stored_freq_reg <= clamp_freq;
            end else if (load_wrap) begin
                stored_freq_reg <= wrap_f[FREQ_W-1:0];
            end
            if (load_tone) begin
                tone_pos_reg <= div_rsp.rem[TONE_W-1:0];
            end
            if (load_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

// ===== rtl/vfo_rem_unit.sv =====
// Restoring remainder unit: one dividend bit per cycle.
`default_nettype none

module vfo_rem_unit (
    input  wire               aclk,
    input  wire               aresetn,
    input  vfo_pkg::div_req_t req,
    output vfo_pkg::div_rsp_t rsp
);
    import vfo_pkg::*;

    logic [DIV_W-1:0]  rem_reg, rem_next;
    logic [DIV_W-1:0]  divisor_reg;
    logic [FREQ_W-1:0] quo_reg;
    logic [4:0]        cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [DIV_W:0]    shifted;

    assign shifted = {rem_reg, quo_reg[FREQ_W-1]};

    always_comb begin
        if (shifted >= {1'b0, divisor_reg}) begin
            rem_next = DIV_W'(shifted - {1'b0, divisor_reg});
        end else begin
            rem_next = shifted[DIV_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == '0);
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'(FREQ_W - 1);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg     <= '0;
            quo_reg     <= req.dividend;
            divisor_reg <= req.divisor;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[FREQ_W-2:0], 1'b0};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.rem  = rem_reg;

endmodule

`default_nettype wire

// ===== rtl/vfo_checker.sv =====
// Port-level assertions for the VFO tuner, bound to the top level.
`default_nettype none

module vfo_checker #(
    parameter int TONE_COUNT = 50
) (
    input wire                           aclk,
    input wire                           aresetn,
    input wire                           s_tvalid,
    input wire                           s_tready,
    input wire [vfo_pkg::S_TDATA_W-1:0]  s_tdata,
    input wire [0:0]                     s_tuser,
    input wire                           m_tvalid,
    input wire                           m_tready,
    input wire [vfo_pkg::M_TDATA_W-1:0]  m_tdata
);
    import vfo_pkg::*;

    // Hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    // One item at a time: input closes after each transaction
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while an item is in work");

    a_tone_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (32'(m_tdata[69:64]) < 32'(TONE_COUNT)))
        else $error("tone index outside the table");

endmodule

bind vfo_tuner_with_tone_select vfo_checker #(.TONE_COUNT(TONE_COUNT)) u_vfo_checker (.*);

`default_nettype wire
